FILE: hw/rtl/soil_water_retention_conductivity_assert.svh
// Assertion macros shared by the checker of the soil water retention block.
// Needs nothing else; included by files that write concurrent assertions.
`ifndef SOIL_WATER_RETENTION_CONDUCTIVITY_ASSERT_SVH
`define SOIL_WATER_RETENTION_CONDUCTIVITY_ASSERT_SVH

// Implication in the same cycle, switched off while reset is applied.
`define SWRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("soil water retention check failed");

// Implication into the following cycle, switched off while reset is applied.
`define SWRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("soil water retention check failed");

`endif

FILE: hw/rtl/swrc_pkg.sv
// Package of the soil water retention block: status codes, pipeline latency,
// the per-stage side word and elaboration-time table functions. No dependencies.
`default_nettype none

package swrc_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    localparam int DIV_STAGES = 16;
    localparam int EXP_FRAC_BITS = 27;
    // Input register, divider setup, divider, three log stages, exponent
    // multiply, power stages, final multiply, output register.
    localparam int SWRC_LATENCY = 1 + 1 + DIV_STAGES + 3 + 1 + EXP_FRAC_BITS + 1 + 1;

    localparam logic [15:0] MULT_RESET = 16'd4096;

    typedef struct packed {
        logic [31:0] mag;
        logic        psi_neg;
        logic [31:0] ks;
        logic [15:0] b;
        logic [15:0] sat;
        logic        inv;
        logic        rz;
    } t_side;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b_m;
        v   = v_in;
        res = 64'd0;
        b_m = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b_m > v) begin
                b_m = b_m >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b_m != 64'd0) begin
                if (v >= res + b_m) begin
                    v   = v - (res + b_m);
                    res = (res >> 1) + b_m;
                end else begin
                    res = res >> 1;
                end
                b_m = b_m >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q2.30, for k of one and up.
    function automatic logic [31:0] grow_const(input int k);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int j = 1; j <= EXP_FRAC_BITS; j++) begin
            if (j <= k) begin
                c = isqrt64(c << 30);
            end
        end
        return c[31:0];
    endfunction

    // 2^(-2^-k) in Q0.32, for k of one and up.
    function automatic logic [31:0] decay_const(input int k);
        logic [63:0] d;
        d = 64'd1 << 31;
        for (int j = 1; j <= EXP_FRAC_BITS; j++) begin
            if (j <= k) begin
                d = isqrt64(d << 32);
            end
        end
        return d[31:0];
    endfunction

    // log2(1 + i / 2^kb) in Q1.16 by repeated squaring; the last entry is 1.0.
    function automatic logic [16:0] log_entry(input int kb, input int i);
        logic [63:0] x;
        logic [16:0] acc;
        acc = 17'd0;
        x   = 64'(((1 << kb) + i)) << (30 - kb);
        if (i >= (1 << kb)) begin
            acc = 17'h10000;
        end else begin
            for (int k = 0; k < 16; k++) begin
                x   = (x * x) >> 30;
                acc = acc << 1;
                if (x >= (64'd1 << 31)) begin
                    x   = x >> 1;
                    acc = acc | 17'd1;
                end
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/soil_water_retention_conductivity.sv
// Top level of the soil water retention and conductivity pipeline.
// Depends on swrc_pkg for status codes, the side word and table functions.
`default_nettype none

// One soil layer enters per clock while busy is low, and its result leaves
// as a one-cycle strobe on o_valid; there is no back-pressure, so results
// must be taken when they appear. The pipeline holds the 16-stage
// bit-per-stage ratio divider and the 27 power-of-two stages, one per fraction
// bit of the exponent. busy is high only while reset is applied and in the
// cycle after. The multiplier register may be rewritten once the pipeline
// holds no items.
module soil_water_retention_conductivity #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic signed [15:0] i_water_content,
    input  logic [15:0] i_saturated_content,
    input  logic [15:0] i_pore_exponent,
    input  logic signed [31:0] i_saturated_potential,
    input  logic [31:0] i_saturated_conductivity,
    output logic        o_valid,
    output logic signed [31:0] o_matric_potential,
    output logic [31:0] o_conductivity,
    output logic [1:0]  o_status
);
    import swrc_pkg::*;

    localparam int SH = 16 - LOG_TABLE_BITS;
    localparam int N_TAB = 1 << LOG_TABLE_BITS;

    logic        r_rdy;
    logic [15:0] r_mult;
    logic [SWRC_LATENCY:1] r_vld;
    logic        n_acc;

    logic [16:0] w_log_tab [0:N_TAB];

    genvar gi;
    generate
        for (gi = 0; gi <= N_TAB; gi++) begin : g_tab
            assign w_log_tab[gi] = log_entry(LOG_TABLE_BITS, gi);
        end
    endgenerate

    assign busy        = ~r_rdy;
    assign o_cfg_ready = r_rdy;
    assign n_acc       = start & r_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy  <= 1'b0;
            r_mult <= MULT_RESET;
            r_vld  <= '0;
        end else begin
            r_rdy <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mult <= i_cfg_data;
            end
            r_vld <= {r_vld[SWRC_LATENCY-1:1], n_acc};
        end
    end

    // Input stage: scaled content and the layer constants.
    logic        n_wc_neg;
    logic [30:0] n_s;
    t_side       n_p1_sd;
    logic [30:0] r_p1_s;
    t_side       r_p1_sd;

    always_comb begin
        n_wc_neg        = i_water_content[15];
        n_s             = n_wc_neg ? 31'd0
                                   : ({16'd0, i_water_content[14:0]} * {15'd0, r_mult});
        n_p1_sd.psi_neg = i_saturated_potential[31];
        n_p1_sd.mag     = i_saturated_potential[31] ? (32'd0 - i_saturated_potential)
                                                    : i_saturated_potential;
        n_p1_sd.ks      = i_saturated_conductivity;
        n_p1_sd.b       = i_pore_exponent;
        n_p1_sd.sat     = i_saturated_content;
        n_p1_sd.inv     = (i_saturated_content == 16'd0) || (n_wc_neg && r_mult != 16'd0);
        n_p1_sd.rz      = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        r_p1_s  <= n_s;
        r_p1_sd <= n_p1_sd;
    end

    // Divider: ratio = floor(s * 32 / sat), clamped at 1.0. A ratio at or above
    // one is caught up front, so the quotient needs only sixteen bits.
    logic [15:0] r_dv_rem [0:DIV_STAGES];
    logic [15:0] r_dv_low [0:DIV_STAGES];
    logic [15:0] r_dv_q   [0:DIV_STAGES];
    logic        r_dv_clamp [0:DIV_STAGES];
    t_side       r_dv_sd  [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        r_dv_rem[0]   <= r_p1_s[26:11];
        r_dv_low[0]   <= {r_p1_s[10:0], 5'd0};
        r_dv_q[0]     <= 16'd0;
        r_dv_clamp[0] <= r_p1_s[30:11] >= {4'd0, r_p1_sd.sat};
        r_dv_sd[0]    <= r_p1_sd;
    end

    genvar gj;
    generate
        for (gj = 1; gj <= DIV_STAGES; gj++) begin : g_div
            logic [16:0] n_t;
            logic        n_ge;
            assign n_t  = {r_dv_rem[gj-1], r_dv_low[gj-1][15]};
            assign n_ge = n_t >= {1'b0, r_dv_sd[gj-1].sat};
            always_ff @(posedge i_clk) begin
                r_dv_rem[gj]   <= n_ge ? 16'(n_t - {1'b0, r_dv_sd[gj-1].sat}) : n_t[15:0];
                r_dv_low[gj]   <= {r_dv_low[gj-1][14:0], 1'b0};
                r_dv_q[gj]     <= {r_dv_q[gj-1][14:0], n_ge};
                r_dv_clamp[gj] <= r_dv_clamp[gj-1];
                r_dv_sd[gj]    <= r_dv_sd[gj-1];
            end
        end
    endgenerate

    // Log stage one: leading one and normalized mantissa fraction.
    logic [16:0] n_l1_r;
    logic [4:0]  n_l1_p;
    logic [16:0] n_l1_m;
    t_side       n_l1_sd;
    logic [4:0]  r_l1_p;
    logic [15:0] r_l1_frac;
    t_side       r_l1_sd;

    always_comb begin
        n_l1_r = r_dv_clamp[DIV_STAGES] ? 17'h10000 : {1'b0, r_dv_q[DIV_STAGES]};
        n_l1_p = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (n_l1_r[i]) begin
                n_l1_p = 5'(i);
            end
        end
        n_l1_m     = n_l1_r << (5'd16 - n_l1_p);
        n_l1_sd    = r_dv_sd[DIV_STAGES];
        n_l1_sd.rz = (n_l1_r == 17'd0);
    end

    always_ff @(posedge i_clk) begin
        r_l1_p    <= n_l1_p;
        r_l1_frac <= n_l1_m[15:0];
        r_l1_sd   <= n_l1_sd;
    end

    // Log stage two: table entries around the mantissa.
    logic [LOG_TABLE_BITS:0] n_l2_idx;
    logic [16:0] n_l2_lo;
    logic [16:0] n_l2_hi;
    logic [4:0]  r_l2_p;
    logic [16:0] r_l2_lo;
    logic [16:0] r_l2_diff;
    logic [SH-1:0] r_l2_rem;
    t_side       r_l2_sd;

    always_comb begin
        n_l2_idx = {1'b0, r_l1_frac[15:SH]};
        n_l2_lo  = w_log_tab[n_l2_idx];
        n_l2_hi  = w_log_tab[n_l2_idx + 1'b1];
    end

    always_ff @(posedge i_clk) begin
        r_l2_p    <= r_l1_p;
        r_l2_lo   <= n_l2_lo;
        r_l2_diff <= n_l2_hi - n_l2_lo;
        r_l2_rem  <= r_l1_frac[SH-1:0];
        r_l2_sd   <= r_l1_sd;
    end

    // Log stage three: interpolate and form -log2(ratio) in Q5.16.
    logic [16+SH:0] n_l3_prod;
    logic [20:0]    n_l3_log;
    logic [20:0]    r_l3_l;
    t_side          r_l3_sd;

    always_comb begin
        n_l3_prod = r_l2_diff * r_l2_rem;
        n_l3_log  = {r_l2_p, 16'd0} + {4'd0, r_l2_lo} + {4'd0, n_l3_prod[16+SH:SH]};
    end

    always_ff @(posedge i_clk) begin
        r_l3_l  <= 21'h100000 - n_l3_log;
        r_l3_sd <= r_l2_sd;
    end

    // Exponent products and the power-of-two chain, one fraction bit a stage.
    logic [36:0] n_y1;
    logic [17:0] n_e2;
    logic [38:0] n_y2;

    logic [26:0] r_pw_f1   [0:EXP_FRAC_BITS];
    logic [26:0] r_pw_f2   [0:EXP_FRAC_BITS];
    logic [4:0]  r_pw_n1   [0:EXP_FRAC_BITS];
    logic [4:0]  r_pw_n2   [0:EXP_FRAC_BITS];
    logic        r_pw_big1 [0:EXP_FRAC_BITS];
    logic        r_pw_big2 [0:EXP_FRAC_BITS];
    logic [30:0] r_pw_up   [0:EXP_FRAC_BITS];
    logic [31:0] r_pw_dn   [0:EXP_FRAC_BITS];
    logic        r_pw_one  [0:EXP_FRAC_BITS];
    t_side       r_pw_sd   [0:EXP_FRAC_BITS];

    always_comb begin
        n_y1 = r_l3_l * r_l3_sd.b;
        n_e2 = 18'd6144 + {1'b0, r_l3_sd.b, 1'b0};
        n_y2 = r_l3_l * n_e2;
    end

    always_ff @(posedge i_clk) begin
        r_pw_f1[0]   <= n_y1[26:0];
        r_pw_f2[0]   <= n_y2[26:0];
        r_pw_n1[0]   <= n_y1[31:27];
        r_pw_n2[0]   <= n_y2[31:27];
        r_pw_big1[0] <= |n_y1[36:32];
        r_pw_big2[0] <= |n_y2[38:32];
        r_pw_up[0]   <= 31'h4000_0000;
        r_pw_dn[0]   <= 32'd0;
        r_pw_one[0]  <= 1'b1;
        r_pw_sd[0]   <= r_l3_sd;
    end

    genvar gk;
    generate
        for (gk = 1; gk <= EXP_FRAC_BITS; gk++) begin : g_pow
            localparam logic [31:0] GROW  = grow_const(gk);
            localparam logic [31:0] DECAY = decay_const(gk);
            logic [62:0] n_pu;
            logic [63:0] n_pd;
            logic        n_b1;
            logic        n_b2;
            assign n_b1 = r_pw_f1[gk-1][EXP_FRAC_BITS-gk];
            assign n_b2 = r_pw_f2[gk-1][EXP_FRAC_BITS-gk];
            assign n_pu = r_pw_up[gk-1] * GROW;
            assign n_pd = r_pw_dn[gk-1] * DECAY;
            always_ff @(posedge i_clk) begin
                r_pw_f1[gk]   <= r_pw_f1[gk-1];
                r_pw_f2[gk]   <= r_pw_f2[gk-1];
                r_pw_n1[gk]   <= r_pw_n1[gk-1];
                r_pw_n2[gk]   <= r_pw_n2[gk-1];
                r_pw_big1[gk] <= r_pw_big1[gk-1];
                r_pw_big2[gk] <= r_pw_big2[gk-1];
                r_pw_up[gk]   <= n_b1 ? n_pu[60:30] : r_pw_up[gk-1];
                if (n_b2) begin
                    r_pw_dn[gk] <= r_pw_one[gk-1] ? DECAY : n_pd[63:32];
                end else begin
                    r_pw_dn[gk] <= r_pw_dn[gk-1];
                end
                r_pw_one[gk]  <= r_pw_one[gk-1] & ~n_b2;
                r_pw_sd[gk]   <= r_pw_sd[gk-1];
            end
        end
    endgenerate

    // Final multiplies by the saturated values.
    logic [62:0] n_f1_t;
    logic [63:0] n_f1_c;
    logic [32:0] r_f1_t;
    logic [31:0] r_f1_c;
    logic [4:0]  r_f1_n1;
    logic [4:0]  r_f1_n2;
    logic        r_f1_big1;
    logic        r_f1_big2;
    t_side       r_f1_sd;

    always_comb begin
        n_f1_t = r_pw_sd[EXP_FRAC_BITS].mag * r_pw_up[EXP_FRAC_BITS];
        n_f1_c = r_pw_sd[EXP_FRAC_BITS].ks * r_pw_dn[EXP_FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        r_f1_t    <= n_f1_t[62:30];
        r_f1_c    <= r_pw_one[EXP_FRAC_BITS] ? r_pw_sd[EXP_FRAC_BITS].ks : n_f1_c[63:32];
        r_f1_n1   <= r_pw_n1[EXP_FRAC_BITS];
        r_f1_n2   <= r_pw_n2[EXP_FRAC_BITS];
        r_f1_big1 <= r_pw_big1[EXP_FRAC_BITS];
        r_f1_big2 <= r_pw_big2[EXP_FRAC_BITS];
        r_f1_sd   <= r_pw_sd[EXP_FRAC_BITS];
    end

    // Output stage: scaling by the integer parts, saturation and special cases.
    logic [31:0] n_limit;
    logic [31:0] n_lim_sh;
    logic [31:0] n_pot;
    logic [31:0] n_cond;
    logic [1:0]  n_st;
    logic [31:0] r_pot;
    logic [31:0] r_cond;
    logic [1:0]  r_st;

    always_comb begin
        n_limit  = r_f1_sd.psi_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        n_lim_sh = n_limit >> r_f1_n1;
        n_pot    = 32'd0;
        n_cond   = 32'd0;
        n_st     = ST_OK;
        if (r_f1_sd.inv) begin
            n_st = ST_INVALID;
        end else if (r_f1_sd.rz) begin
            if (r_f1_sd.b == 16'd0) begin
                n_pot = r_f1_sd.mag;
            end else if (r_f1_sd.mag != 32'd0) begin
                n_pot = n_limit;
                n_st  = ST_SAT;
            end
        end else begin
            if (r_f1_sd.mag == 32'd0) begin
                n_pot = 32'd0;
            end else if (r_f1_big1 || r_f1_t > {1'b0, n_lim_sh}) begin
                n_pot = n_limit;
                n_st  = ST_SAT;
            end else begin
                n_pot = r_f1_t[31:0] << r_f1_n1;
            end
            n_cond = r_f1_big2 ? 32'd0 : (r_f1_c >> r_f1_n2);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pot  <= r_f1_sd.psi_neg ? (32'd0 - n_pot) : n_pot;
        r_cond <= n_cond;
        r_st   <= n_st;
    end

    assign o_valid            = r_vld[SWRC_LATENCY];
    assign o_matric_potential = r_pot;
    assign o_conductivity     = r_cond;
    assign o_status           = r_st;

endmodule

`default_nettype wire

FILE: hw/rtl/swrc_chk.sv
// Port-level checker for the soil water retention block, with its bind.
// Depends on swrc_pkg and soil_water_retention_conductivity_assert.svh.
`default_nettype none

`include "soil_water_retention_conductivity_assert.svh"

module swrc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_cfg_ready,
    input logic        o_valid,
    input logic [31:0] o_matric_potential,
    input logic [31:0] o_conductivity,
    input logic [1:0]  o_status
);
    import swrc_pkg::*;

    logic w_acc;
    logic w_code_ok;
    logic w_both_zero;
    logic w_at_limit;
    logic w_inv_out;
    logic w_sat_out;

    assign w_acc       = start && !busy;
    assign w_code_ok   = (o_status == ST_OK) || (o_status == ST_INVALID) || (o_status == ST_SAT);
    assign w_both_zero = (o_matric_potential == 32'd0) && (o_conductivity == 32'd0);
    assign w_at_limit  = (o_matric_potential == 32'h7FFF_FFFF)
                      || (o_matric_potential == 32'h8000_0000);
    assign w_inv_out   = o_valid && (o_status == ST_INVALID);
    assign w_sat_out   = o_valid && (o_status == ST_SAT);

    // Every result word goes back to a word taken a fixed latency earlier.
    `SWRC_ASSERT_IMP(a_out_from_in, i_clk, i_rst_n, o_valid, $past(w_acc, SWRC_LATENCY))
    `SWRC_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid, w_code_ok)
    `SWRC_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, w_inv_out, w_both_zero)
    `SWRC_ASSERT_IMP(a_sat_limit, i_clk, i_rst_n, w_sat_out, w_at_limit)
    `SWRC_ASSERT_NXT(a_ready_after_reset, i_clk, i_rst_n, i_rst_n, (!busy && o_cfg_ready))

endmodule

bind soil_water_retention_conductivity swrc_chk u_swrc_chk (.*);

`default_nettype wire

FILE: sim/soil_water_retention_conductivity_tb.sv
// Self-checking testbench for the soil water retention and conductivity pipeline.
// Depends on swrc_pkg (status codes, latency) and the soil_water_retention_conductivity RTL.
`default_nettype none

module soil_water_retention_conductivity_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swrc_pkg::*;

    localparam int TBL_BITS = 8;
    localparam int FRAC_BITS = 27;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0] wc;
        logic [15:0] sat;
        logic [15:0] b;
        logic [31:0] psi;
        logic [31:0] ks;
    } layer_t;

    typedef struct {
        logic [31:0] pot;
        logic [31:0] cond;
        logic [1:0]  status;
    } soil_out_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic signed [15:0] i_water_content;
    logic [15:0] i_saturated_content;
    logic [15:0] i_pore_exponent;
    logic signed [31:0] i_saturated_potential;
    logic [31:0] i_saturated_conductivity;
    logic        o_valid;
    logic signed [31:0] o_matric_potential;
    logic [31:0] o_conductivity;
    logic [1:0]  o_status;

    soil_water_retention_conductivity u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_water_content(i_water_content), .i_saturated_content(i_saturated_content),
        .i_pore_exponent(i_pore_exponent), .i_saturated_potential(i_saturated_potential),
        .i_saturated_conductivity(i_saturated_conductivity),
        .o_valid(o_valid), .o_matric_potential(o_matric_potential),
        .o_conductivity(o_conductivity), .o_status(o_status)
    );

    layer_t      layer_q[$];
    soil_out_t   soil_q[$];
    logic [15:0] mult_now;
    bit          idle_on;
    int          n_err;
    int          cyc;

    longint unsigned log_tbl[0:(1 << TBL_BITS)];
    longint unsigned grow_tbl[0:FRAC_BITS];
    longint unsigned decay_tbl[0:FRAC_BITS];

    function automatic longint unsigned int_sqrt(input longint unsigned v_in);
        longint unsigned v, res, bt;
        v = v_in;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    task automatic fill_tables();
        longint unsigned x, acc, c, d;
        for (int i = 0; i < (1 << TBL_BITS); i++) begin
            x = longint'((1 << TBL_BITS) + i) << (30 - TBL_BITS);
            acc = 0;
            for (int k = 0; k < 16; k++) begin
                x = (x * x) >> 30;
                acc = acc << 1;
                if (x >= (64'd1 << 31)) begin
                    x = x >> 1;
                    acc = acc | 1;
                end
            end
            log_tbl[i] = acc;
        end
        log_tbl[1 << TBL_BITS] = 65536;
        c = 64'd1 << 31;
        d = 64'd1 << 31;
        grow_tbl[0] = c;
        decay_tbl[0] = d;
        for (int k = 1; k <= FRAC_BITS; k++) begin
            c = int_sqrt(c << 30);
            d = int_sqrt(d << 32);
            grow_tbl[k] = c;
            decay_tbl[k] = d;
        end
    endtask

    // log2 of a ratio in 1..65536, Q5.16, with table interpolation.
    function automatic longint unsigned ratio_log2(input longint unsigned r);
        longint unsigned p, m, fr, idx, rem, lo, hi;
        int sh;
        sh = 16 - TBL_BITS;
        p = 16;
        while (p > 0 && ((r >> p) & 1) == 0) p--;
        m = r << (16 - p);
        fr = (m - 65536) & 64'hFFFF;
        idx = fr >> sh;
        rem = fr & ((64'd1 << sh) - 1);
        lo = log_tbl[idx];
        hi = log_tbl[idx + 1];
        return (p << 16) + lo + (((hi - lo) * rem) >> sh);
    endfunction

    function automatic longint unsigned frac_grow(input longint unsigned f);
        longint unsigned acc;
        acc = 64'd1 << 30;
        for (int k = 1; k <= FRAC_BITS; k++)
            if ((f >> (FRAC_BITS - k)) & 1) acc = (acc * grow_tbl[k]) >> 30;
        return acc;
    endfunction

    function automatic longint unsigned frac_decay(input longint unsigned f);
        longint unsigned acc;
        acc = 64'd1 << 32;
        for (int k = 1; k <= FRAC_BITS; k++)
            if ((f >> (FRAC_BITS - k)) & 1) acc = (acc * decay_tbl[k]) >> 32;
        return acc;
    endfunction

    function automatic soil_out_t predict_layer(input layer_t it, input logic [15:0] mult);
        soil_out_t res;
        bit wneg, pneg;
        longint unsigned mag, lim, pot, cond, s, r, l, y1, y2, n1, n2, msk, t;
        wneg = it.wc[15];
        pneg = it.psi[31];
        mag = pneg ? ((64'd1 << 32) - it.psi) : it.psi;
        lim = pneg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
        pot = 0;
        cond = 0;
        res.status = ST_OK;
        if (it.sat == 0 || (wneg && mult != 0)) begin
            res.status = ST_INVALID;
        end else begin
            s = wneg ? 0 : longint'(it.wc) * mult;
            r = (s * 32) / it.sat;
            if (r > 65536) r = 65536;
            if (r == 0) begin
                if (it.b == 0) begin
                    pot = mag;
                end else if (mag != 0) begin
                    pot = lim;
                    res.status = ST_SAT;
                end
            end else begin
                l = (64'd16 << 16) - ratio_log2(r);
                msk = (64'd1 << FRAC_BITS) - 1;
                y1 = l * it.b;
                y2 = l * (3 * 2048 + 2 * longint'(it.b));
                n1 = y1 >> FRAC_BITS;
                n2 = y2 >> FRAC_BITS;
                if (mag != 0) begin
                    if (n1 >= 32) begin
                        pot = lim;
                        res.status = ST_SAT;
                    end else begin
                        t = (mag * frac_grow(y1 & msk)) >> 30;
                        if (t > (lim >> n1)) begin
                            pot = lim;
                            res.status = ST_SAT;
                        end else begin
                            pot = t << n1;
                        end
                    end
                end
                if (n2 < 32) cond = ((it.ks * frac_decay(y2 & msk)) >> 32) >> n2;
            end
        end
        if (pneg) pot = (64'd1 << 32) - pot;
        res.pot = pot[31:0];
        res.cond = cond[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cyc, what, got, want);
        n_err++;
    endtask

    function automatic layer_t mk_layer(input logic [15:0] wc, input logic [15:0] sat,
                                        input logic [15:0] b, input logic [31:0] psi,
                                        input logic [31:0] ks);
        layer_t it;
        it.wc = wc;
        it.sat = sat;
        it.b = b;
        it.psi = psi;
        it.ks = ks;
        return it;
    endfunction

    function automatic layer_t rand_layer();
        layer_t it;
        it.wc = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32767));
        case ($urandom_range(0, 19))
            0: it.sat = 16'd0;
            1, 2, 3: it.sat = 16'($urandom);
            default: it.sat = 16'($urandom_range(16384, 65535));
        endcase
        it.b = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383));
        it.psi = $urandom;
        if ($urandom_range(0, 1)) it.psi = 32'($signed(it.psi) >>> $urandom_range(0, 24));
        it.ks = $urandom;
        return it;
    endfunction

    task automatic drain();
        while (layer_q.size() != 0 || soil_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mult(input logic [15:0] v);
        drain();
        repeat (SWRC_LATENCY + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        mult_now = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The sender offers one queued layer per cycle while busy is low; idle_on adds gaps.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            soil_q.push_back(predict_layer(mk_layer(i_water_content, i_saturated_content,
                i_pore_exponent, i_saturated_potential, i_saturated_conductivity), mult_now));
        end
        if (!(start && busy)) begin
            if (i_rst_n && layer_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < 35)) begin
                layer_t it;
                it = layer_q.pop_front();
                start <= 1'b1;
                i_water_content <= it.wc;
                i_saturated_content <= it.sat;
                i_pore_exponent <= it.b;
                i_saturated_potential <= it.psi;
                i_saturated_conductivity <= it.ks;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        soil_out_t want;
        if (i_rst_n && o_valid) begin
            if (soil_q.size() == 0) begin
                report_mismatch("unexpected word", o_matric_potential, 32'd0);
            end else begin
                want = soil_q.pop_front();
                if (o_matric_potential !== want.pot)
                    report_mismatch("potential", o_matric_potential, want.pot);
                if (o_conductivity !== want.cond)
                    report_mismatch("conductivity", o_conductivity, want.cond);
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [15:0] mults[5];
        fill_tables();
        n_err = 0;
        cyc = 0;
        idle_on = 1'b1;
        mult_now = MULT_RESET;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_water_content = '0;
        i_saturated_content = '0;
        i_pore_exponent = '0;
        i_saturated_potential = '0;
        i_saturated_conductivity = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners under the reset multiplier.
        layer_q.push_back(mk_layer(16'h4000, 16'd0, 16'd2048, 32'd1000, 32'd5000));
        layer_q.push_back(mk_layer(16'h8000, 16'hFFFF, 16'd2048, 32'd1000, 32'd5000));
        layer_q.push_back(mk_layer(16'h0000, 16'h8000, 16'd0, 32'hFFFF_0000, 32'd77));
        layer_q.push_back(mk_layer(16'h0000, 16'h8000, 16'd100, 32'd0, 32'd77));
        layer_q.push_back(mk_layer(16'h0000, 16'h8000, 16'd100, 32'd12345, 32'd77));
        layer_q.push_back(mk_layer(16'h0000, 16'h8000, 16'd100, 32'h8000_0000, 32'd77));
        layer_q.push_back(mk_layer(16'h7FFF, 16'd1, 16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        layer_q.push_back(mk_layer(16'h7FFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        layer_q.push_back(mk_layer(16'h0001, 16'hFFFF, 16'hFFFF, 32'd1000, 32'hFFFF_FFFF));
        layer_q.push_back(mk_layer(16'h0001, 16'hFFFF, 16'd1024, 32'h7FFF_FFFF, 32'd9));
        layer_q.push_back(mk_layer(16'h4000, 16'h8000, 16'd0, 32'hFFFF_FFFF, 32'd1 << 31));
        layer_q.push_back(mk_layer(16'h2000, 16'h8000, 16'd8192, 32'h7FFF_0000, 32'd1 << 20));
        layer_q.push_back(mk_layer(16'h2000, 16'h8000, 16'd8192, -32'sd50000, 32'd1 << 20));
        layer_q.push_back(mk_layer(16'h1234, 16'h5678, 16'd6000, -32'sd1, 32'd1));
        for (int i = 0; i < 140; i++) layer_q.push_back(rand_layer());
        // Wait until the pipeline has emptied, then run the next batch without gaps.
        drain();
        idle_on = 1'b0;
        for (int i = 0; i < 100; i++) layer_q.push_back(rand_layer());
        drain();
        idle_on = 1'b1;

        mults[0] = 16'd0;
        mults[1] = 16'hFFFF;
        mults[2] = 16'($urandom);
        mults[3] = 16'd1;
        mults[4] = MULT_RESET;
        foreach (mults[m]) begin
            write_mult(mults[m]);
            // Negative content with a zero multiplier counts as ratio zero.
            layer_q.push_back(mk_layer(16'hFFFF, 16'h8000, 16'd300, 32'd4000, 32'd99));
            layer_q.push_back(mk_layer(16'h8000, 16'h8000, 16'd0, -32'sd4000, 32'd99));
            for (int i = 0; i < 90; i++) layer_q.push_back(rand_layer());
        end
        drain();
        repeat (SWRC_LATENCY + 10) @(posedge i_clk);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: soil_water_retention_conductivity.f
+incdir+hw/rtl
hw/rtl/swrc_pkg.sv
hw/rtl/soil_water_retention_conductivity.sv
hw/rtl/swrc_chk.sv
sim/soil_water_retention_conductivity_tb.sv
